// ===== sv/dark_channel_window_min_top_assert.svh =====
// Assertion macros for the dark channel window minimum block.
// Both macros sample on the rising edge of clock and are off while reset is high.
`ifndef DARK_CHANNEL_WINDOW_MIN_TOP_ASSERT_SVH
`define DARK_CHANNEL_WINDOW_MIN_TOP_ASSERT_SVH

// The condition must hold in the same cycle.
`define DCWM_ASSERT_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("dark channel window check failed");

// The condition must hold in the next cycle.
`define DCWM_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("dark channel window check failed");

`endif

// ===== sv/dcwm_pkg.sv =====
package dcwm_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_RADIUS  = 7;
   localparam int MAX_HEIGHT  = 4096;
   localparam int NCELL       = 2 * MAX_RADIUS + 1;
   localparam int CELL_IW     = $clog2(NCELL);
   localparam int STORE_DEPTH = (2 * MAX_RADIUS + 2) * MAX_WIDTH;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int PIX_W       = 8;
   localparam int CSR_AW      = 4;

   localparam logic [PIX_W-1:0] NEUTRAL = 8'hFF;

   localparam logic [1:0] REG_RADIUS = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   typedef struct packed {
      logic             clear;
      logic             shift;
      logic [PIX_W-1:0] din;
   } chain_ctrl_type;

   function automatic logic [PIX_W-1:0] min8(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

// ===== sv/dcwm_cell.sv =====
module dcwm_cell (
   input  logic                          clock,
   input  dcwm_pkg::chain_ctrl_type      ctrl,
   input  logic [dcwm_pkg::PIX_W-1:0]    neighbor_in,
   output logic [dcwm_pkg::PIX_W-1:0]    value
);
   import dcwm_pkg::*;

   logic [PIX_W-1:0] value_ff;
   logic [PIX_W-1:0] value_in;

   // A cleared cell holds the neutral value, which never lowers a minimum.
   always_comb begin
      value_in = value_ff;
      if (ctrl.clear) begin
         value_in = NEUTRAL;
      end else if (ctrl.shift) begin
         value_in = neighbor_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== sv/dcwm_chain.sv =====
module dcwm_chain (
   input  logic                          clock,
   input  dcwm_pkg::chain_ctrl_type      ctrl,
   input  logic [2:0]                    radius,
   output logic [dcwm_pkg::PIX_W-1:0]    win_min
);
   import dcwm_pkg::*;

   localparam int TREE_N = 1 << CELL_IW;

   logic [PIX_W-1:0] cell_val [NCELL];

   // Cell j holds the column minimum of column (center + radius - j).
   for (genvar j = 0; j < NCELL; j++) begin : g_cell
      if (j == 0) begin : g_head
         dcwm_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .neighbor_in (ctrl.din),
            .value       (cell_val[j])
         );
      end else begin : g_body
         dcwm_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .neighbor_in (cell_val[j-1]),
            .value       (cell_val[j])
         );
      end
   end

   // Cells past 2*radius lie outside the window and are masked off.
   always_comb begin
      logic [PIX_W-1:0] tree [1:2*TREE_N-1];
      for (int j = 0; j < TREE_N; j++) begin
         if (j < NCELL && j <= 2 * int'(radius)) begin
            tree[TREE_N + j] = cell_val[j];
         end else begin
            tree[TREE_N + j] = NEUTRAL;
         end
      end
      for (int i = TREE_N - 1; i >= 1; i--) begin
         tree[i] = min8(tree[2*i], tree[2*i+1]);
      end
      win_min = tree[1];
   end

endmodule

// ===== sv/dark_channel_window_min_top.sv =====
// Dark channel window minimum.
// Pixels enter on the req_ stream in raster order (tuser 0 = pixel, 1 = drain
// beat); each pixel's smallest channel is written to a ring of line storage.
// Once radius*width+radius beats of a frame have arrived, every further beat
// yields one rsp_ beat: the minimum over the window of radius pixels on each
// side, clipped at the frame borders. Drain beats flush the tail of a frame,
// and rsp_tlast marks the frame's last result.
// Column minima are gathered by reading the rows of one window column from
// the single-port line store, one row per cycle, and pushed into a row of
// 2*MAX_RADIUS+1 cells whose masked minimum gives the result.
// A beat that gives no result leaves the block ready for the next one. A beat
// with a result holds off further beats while a column, or at a row start
// the right half of the window, is read through the line store's read port.
// Reset restores the registers to radius 1, width 640, height 480 and starts
// a new frame; a register write also starts a new frame. When the receiver
// stalls, the finished result waits in the output register while the next
// beat is taken; the block only halts before writing a second result.
module dark_channel_window_min_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,   // blue, green, red
   input  logic                          req_tuser,   // req_type
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // dark_value
   output logic                          rsp_tlast,   // frame_end
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [dcwm_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import dcwm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SETUP, ST_COLUMN, ST_READ, ST_LAST, ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [2:0]          radius_ff, radius_in;
   logic [10:0]         width_ff, width_in;
   logic [12:0]         height_ff, height_in;
   logic                cfg_wait_ff, cfg_wait_in;
   logic [22:0]         total_ff, total_in;
   logic [12:0]         lag_ff, lag_in;
   logic [22:0]         item_cnt_ff, item_cnt_in;
   logic [22:0]         pix_cnt_ff, pix_cnt_in;
   logic [11:0]         out_row_ff, out_row_in;
   logic [9:0]          out_col_ff, out_col_in;
   logic [STORE_AW-1:0] row_base_ff, row_base_in;
   logic [3:0]          rows_total_ff, rows_total_in;
   logic [3:0]          rows_left_ff, rows_left_in;
   logic [10:0]         col_n_ff, col_n_in;
   logic [3:0]          cols_left_ff, cols_left_in;
   logic [STORE_AW-1:0] addr_ff, addr_in;
   logic [PIX_W-1:0]    vmin_ff, vmin_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rd_vld_ff;
   logic [PIX_W-1:0]    rdata_ff;

   logic [PIX_W-1:0]    mem [STORE_DEPTH];
   logic                mem_we, mem_re;
   logic [PIX_W-1:0]    mem_wdata;

   logic [10:0]         eff_w;
   logic [12:0]         eff_h;
   logic                cfg_write, accept, frame_last;
   logic [1:0]          cfg_idx;
   logic [11:0]         r0;
   logic [12:0]         row_hi, r1;
   logic [22:0]         base_full;
   logic [PIX_W-1:0]    pix_min, col_final, win_min;
   chain_ctrl_type      chain_ctrl;

   // Out-of-range register values are clipped to the supported frame.
   always_comb begin
      if (width_ff == '0) begin
         eff_w = 11'd1;
      end else if (width_ff > 11'(MAX_WIDTH)) begin
         eff_w = 11'(MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
      if (height_ff == '0) begin
         eff_h = 13'd1;
      end else if (height_ff > 13'(MAX_HEIGHT)) begin
         eff_h = 13'(MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   always_comb begin
      case (cfg_idx)
         REG_RADIUS: csr_prdata = {29'd0, radius_ff};
         REG_WIDTH:  csr_prdata = {21'd0, width_ff};
         REG_HEIGHT: csr_prdata = {19'd0, height_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE) && !cfg_wait_ff;
   assign accept     = req_tvalid && req_tready;
   assign pix_min    = min8(min8(req_tdata[7:0], req_tdata[15:8]), req_tdata[23:16]);
   assign mem_wdata  = req_tuser ? NEUTRAL : pix_min;
   assign mem_we     = accept && (pix_cnt_ff < total_ff);
   assign mem_re     = (state_ff == ST_READ);

   // Window rows for the current output, clipped at top and bottom.
   assign r0        = (out_row_ff >= 12'(radius_ff)) ? out_row_ff - 12'(radius_ff) : 12'd0;
   assign row_hi    = 13'(out_row_ff) + 13'(radius_ff);
   assign r1        = (row_hi < eff_h) ? row_hi : eff_h - 13'd1;
   assign base_full = {11'd0, r0} * {12'd0, eff_w};
   assign col_final = min8(vmin_ff, rdata_ff);
   assign frame_last = (out_row_ff == 12'(eff_h - 13'd1)) &&
                       (out_col_ff == 10'(eff_w - 11'd1));

   always_comb begin
      state_in      = state_ff;
      radius_in     = radius_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      cfg_wait_in   = 1'b0;
      total_in      = {12'd0, eff_w} * {10'd0, eff_h};
      lag_in        = 13'(({3'd0, eff_w} * {11'd0, radius_ff}) + 14'(radius_ff));
      item_cnt_in   = item_cnt_ff;
      pix_cnt_in    = pix_cnt_ff;
      out_row_in    = out_row_ff;
      out_col_in    = out_col_ff;
      row_base_in   = row_base_ff;
      rows_total_in = rows_total_ff;
      rows_left_in  = rows_left_ff;
      col_n_in      = col_n_ff;
      cols_left_in  = cols_left_ff;
      addr_in       = addr_ff;
      vmin_in       = vmin_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      chain_ctrl    = '{clear: 1'b0, shift: 1'b0, din: NEUTRAL};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_cnt_in = item_cnt_ff + 23'd1;
               if (mem_we) begin
                  pix_cnt_in = pix_cnt_ff + 23'd1;
               end
               if (item_cnt_ff >= 23'(lag_ff)) begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            row_base_in   = base_full[STORE_AW-1:0];
            rows_total_in = 4'(r1 - 13'(r0));
            if (out_col_ff == '0) begin
               // Row start: rebuild the whole right half of the window.
               chain_ctrl.clear = 1'b1;
               col_n_in         = 11'd0;
               cols_left_in     = 4'(radius_ff);
            end else begin
               col_n_in     = 11'(out_col_ff) + 11'(radius_ff);
               cols_left_in = 4'd0;
            end
            state_in = ST_COLUMN;
         end
         ST_COLUMN: begin
            if (col_n_ff >= eff_w) begin
               // Column past the right border: push the neutral value.
               chain_ctrl.shift = 1'b1;
               chain_ctrl.din   = NEUTRAL;
               if (cols_left_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  cols_left_in = cols_left_ff - 4'd1;
                  col_n_in     = col_n_ff + 11'd1;
               end
            end else begin
               addr_in      = row_base_ff + STORE_AW'(col_n_ff);
               rows_left_in = rows_total_ff;
               vmin_in      = NEUTRAL;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            addr_in = addr_ff + STORE_AW'(eff_w);
            if (rd_vld_ff) begin
               vmin_in = col_final;
            end
            if (rows_left_ff == '0) begin
               state_in = ST_LAST;
            end else begin
               rows_left_in = rows_left_ff - 4'd1;
            end
         end
         ST_LAST: begin
            chain_ctrl.shift = 1'b1;
            chain_ctrl.din   = col_final;
            if (cols_left_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               cols_left_in = cols_left_ff - 4'd1;
               col_n_in     = col_n_ff + 11'd1;
               state_in     = ST_COLUMN;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = win_min;
               rsp_last_in  = frame_last;
               if (frame_last) begin
                  item_cnt_in = '0;
                  pix_cnt_in  = '0;
                  out_row_in  = '0;
                  out_col_in  = '0;
               end else if (out_col_ff == 10'(eff_w - 11'd1)) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + 12'd1;
               end else begin
                  out_col_in = out_col_ff + 10'd1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A register write restarts the frame.
      if (cfg_write && (cfg_idx == REG_RADIUS || cfg_idx == REG_WIDTH ||
                        cfg_idx == REG_HEIGHT)) begin
         case (cfg_idx)
            REG_RADIUS: radius_in = csr_pwdata[2:0];
            REG_WIDTH:  width_in  = csr_pwdata[10:0];
            REG_HEIGHT: height_in = csr_pwdata[12:0];
            default:    radius_in = radius_ff;
         endcase
         cfg_wait_in = 1'b1;
         item_cnt_in = '0;
         pix_cnt_in  = '0;
         out_row_in  = '0;
         out_col_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= 3'd1;
         width_ff     <= 11'd640;
         height_ff    <= 13'd480;
         cfg_wait_ff  <= 1'b1;
         item_cnt_ff  <= '0;
         pix_cnt_ff   <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         cfg_wait_ff  <= cfg_wait_in;
         item_cnt_ff  <= item_cnt_in;
         pix_cnt_ff   <= pix_cnt_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= mem_re;
      end
      total_ff      <= total_in;
      lag_ff        <= lag_in;
      row_base_ff   <= row_base_in;
      rows_total_ff <= rows_total_in;
      rows_left_ff  <= rows_left_in;
      col_n_ff      <= col_n_in;
      cols_left_ff  <= cols_left_in;
      addr_ff       <= addr_in;
      vmin_ff       <= vmin_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Line store: ring of per-pixel channel minima, indexed by pixel number.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[pix_cnt_ff[STORE_AW-1:0]] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[addr_ff];
      end
   end

   dcwm_chain u_chain (
      .clock   (clock),
      .ctrl    (chain_ctrl),
      .radius  (radius_ff),
      .win_min (win_min)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`include "dark_channel_window_min_top_assert.svh"

   `DCWM_ASSERT_IMP(a_store_one_port, mem_we, !mem_re)
   `DCWM_ASSERT_IMP(a_last_restarts, rsp_valid_ff && rsp_last_ff, out_row_ff == '0 && out_col_ff == '0)
   `DCWM_ASSERT_NEXT(a_read_lands, state_ff == ST_READ && rows_left_ff == '0, state_ff == ST_LAST && rd_vld_ff)

endmodule

// ===== tb/dark_channel_window_min_checker.sv =====
// Watches the pixel, result and register channels of the dark channel block.
// It keeps its own copy of the registers, the frame counters and the ring of
// per-pixel minima, and predicts each result beat from them.
module dark_channel_window_min_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // blue, green, red
   input  logic        req_tuser,   // req_type
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // dark_value
   input  logic        rsp_tlast,   // frame_end
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [dcwm_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);
   import dcwm_pkg::*;

   typedef struct packed {
      logic [7:0] dark_value;
      logic       frame_end;
   } dark_result_type;

   dark_result_type expected_dark[$];
   logic [7:0]   pixel_min_ring[STORE_DEPTH];
   logic [2:0]   radius_reg;
   logic [10:0]  width_reg;
   logic [12:0]  height_reg;
   int unsigned  frame_items;
   int unsigned  frame_pixels;

   initial fail_count = 0;
   initial pending = 0;

   task automatic report(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic int unsigned eff_radius();
      return (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
   endfunction

   function automatic int unsigned eff_width();
      if (width_reg == 0) return 1;
      return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
   endfunction

   function automatic int unsigned eff_height();
      if (height_reg == 0) return 1;
      return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
   endfunction

   // Minimum over the window around output pixel o, clipped at the borders.
   function automatic logic [7:0] window_minimum(input int unsigned o, input int unsigned w,
                                                 input int unsigned h, input int unsigned r);
      int unsigned row, col, r0, r1, c0, c1;
      logic [7:0]  best;
      row  = o / w;
      col  = o % w;
      r0   = (row >= r) ? row - r : 0;
      r1   = (row + r < h) ? row + r : h - 1;
      c0   = (col >= r) ? col - r : 0;
      c1   = (col + r < w) ? col + r : w - 1;
      best = NEUTRAL;
      for (int unsigned m = r0; m <= r1; m++)
         for (int unsigned n = c0; n <= c1; n++)
            if (pixel_min_ring[(m * w + n) % STORE_DEPTH] < best)
               best = pixel_min_ring[(m * w + n) % STORE_DEPTH];
      return best;
   endfunction

   task automatic take_pixel_beat(input logic drain, input logic [23:0] data);
      int unsigned  w, h, r, total, lag, k, o;
      logic [7:0]   v;
      dark_result_type res;
      w     = eff_width();
      h     = eff_height();
      r     = eff_radius();
      total = w * h;
      lag   = r * w + r;
      k     = frame_items;
      if (frame_pixels < total) begin
         v = NEUTRAL;
         if (!drain) begin
            v = data[7:0];
            if (data[15:8] < v) v = data[15:8];
            if (data[23:16] < v) v = data[23:16];
         end
         pixel_min_ring[frame_pixels % STORE_DEPTH] = v;
         frame_pixels++;
      end
      frame_items = k + 1;
      if (k >= lag) begin
         o = k - lag;
         if (o >= total) begin
            frame_items  = 0;
            frame_pixels = 0;
         end else begin
            res.dark_value = window_minimum(o, w, h, r);
            res.frame_end  = (o == total - 1);
            expected_dark.push_back(res);
            if (res.frame_end) begin
               frame_items  = 0;
               frame_pixels = 0;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      dark_result_type exp_res;
      if (reset) begin
         radius_reg   = 3'd1;
         width_reg    = 11'd640;
         height_reg   = 13'd480;
         frame_items  = 0;
         frame_pixels = 0;
         expected_dark.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_dark.size() == 0) begin
               report($sformatf("unexpected result beat dark=%0d last=%0b",
                                rsp_tdata, rsp_tlast));
            end else begin
               exp_res = expected_dark.pop_front();
               if (rsp_tdata !== exp_res.dark_value)
                  report($sformatf("dark_value got %0d expected %0d",
                                   rsp_tdata, exp_res.dark_value));
               if (rsp_tlast !== exp_res.frame_end)
                  report($sformatf("frame_end got %0b expected %0b",
                                   rsp_tlast, exp_res.frame_end));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[3:2] == REG_RADIUS) begin
               radius_reg = csr_pwdata[2:0];
               frame_items = 0;
               frame_pixels = 0;
            end else if (csr_paddr[3:2] == REG_WIDTH) begin
               width_reg = csr_pwdata[10:0];
               frame_items = 0;
               frame_pixels = 0;
            end else if (csr_paddr[3:2] == REG_HEIGHT) begin
               height_reg = csr_pwdata[12:0];
               frame_items = 0;
               frame_pixels = 0;
            end
         end
         if (req_tvalid && req_tready)
            take_pixel_beat(req_tuser, req_tdata);
      end
      pending = expected_dark.size();
   end
endmodule

// ===== tb/dark_channel_window_min_top_test.sv =====
// Top of the dark channel window test. It drives pixel and drain beats in
// bursts, stalls the result side on a shifting pattern, and writes the
// registers between phases. All prediction and comparison lives in the
// checker instance; this module only makes stimulus and gives the verdict.
module dark_channel_window_min_top_test;
   import dcwm_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;    // blue, green, red
   logic        req_tuser = 1'b0;  // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // dark_value
   logic        rsp_tlast;         // frame_end
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          fail_count;
   int          pending;

   // Effective settings as the block will use them, for sizing frames.
   int unsigned cur_radius = 1;
   int unsigned cur_width  = 640;
   int unsigned cur_height = 480;
   int          burst_left = 0;
   int          random_beats = 0;
   int unsigned rx_cycle = 0;

   dark_channel_window_min_top DUT (.*);

   dark_channel_window_min_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The receiver cycles through three moods: always ready, coin-flip
   // stalls, and long stalls that hold the result register full.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         case ((rx_cycle >> 8) % 3)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom);
            default: rsp_tready <= (rx_cycle % 40) >= 30;
         endcase
      end
   end

   // One beat on the pixel stream. Bursts of random length are separated by
   // random gaps, so idle cycles land on every phase of the block's work.
   task automatic send_beat(input logic drain, input logic [7:0] blue,
                            input logic [7:0] green, input logic [7:0] red);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= drain;
      req_tdata  <= {red, green, blue};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Register access: setup cycle, access cycle, wait for pready, then return to
   // idle before the next access.
   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Registers change only with the block idle: every expected result in,
   // then enough slack for a result that is still being worked out.
   task automatic set_config(input int unsigned radius, input int unsigned width,
                             input int unsigned height);
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (200) @(posedge clock);
      csr_write(REG_RADIUS, radius);
      csr_write(REG_WIDTH, width);
      csr_write(REG_HEIGHT, height);
      cur_radius = radius & 7;
      cur_width  = width & 11'h7FF;
      cur_height = height & 13'h1FFF;
      if (cur_width == 0) cur_width = 1;
      if (cur_width > MAX_WIDTH) cur_width = MAX_WIDTH;
      if (cur_height == 0) cur_height = 1;
      if (cur_height > MAX_HEIGHT) cur_height = MAX_HEIGHT;
   endtask

   function automatic logic [7:0] channel_value();
      case ($urandom % 8)
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // A frame of total+lag beats: mostly pixels first (with a few early
   // drains), then mostly drains (with a few pixels that count as drains).
   // A frame may be cut short, leaving the next register write to restart.
   task automatic run_frame(input bit cut_short, input bit pause_midway);
      int unsigned total, n;
      logic        drain;
      total = cur_width * cur_height;
      n     = total + cur_radius * cur_width + cur_radius;
      if (cut_short) n = $urandom_range(1, n);
      for (int unsigned i = 0; i < n; i++) begin
         if (pause_midway && i == n / 2) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            wait (pending == 0);
            @(posedge clock);
         end
         drain = (i < total) ? ($urandom % 100 < 8) : ($urandom % 100 < 85);
         send_beat(drain, channel_value(), channel_value(), channel_value());
         random_beats++;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default registers: a lag of 641 beats, so a short run gives nothing.
      for (int i = 0; i < 10; i++) send_beat(i % 3 == 2, 8'hFF, 8'h00, 8'h80);

      // Single-pixel frames: each beat is a whole frame and gives its result.
      set_config(0, 1, 1);
      send_beat(1'b0, 8'hFF, 8'hFF, 8'hFF);
      send_beat(1'b0, 8'h00, 8'hFF, 8'hFF);
      send_beat(1'b0, 8'hFF, 8'h00, 8'hFF);
      send_beat(1'b0, 8'hFF, 8'hFF, 8'h00);
      send_beat(1'b0, 8'h7E, 8'h81, 8'hA5);
      send_beat(1'b1, 8'h00, 8'h00, 8'h00);

      // Width and height of zero act as one; with radius one the pixel after
      // the frame is complete is treated as a drain beat.
      set_config(1, 0, 0);
      send_beat(1'b0, 8'h11, 8'h22, 8'h33);
      send_beat(1'b0, 8'h00, 8'h00, 8'h00);
      send_beat(1'b1, 8'h00, 8'h00, 8'h00);

      // A small frame with an early drain inside it.
      set_config(2, 3, 2);
      send_beat(1'b1, 8'h00, 8'h00, 8'h00);
      for (int i = 0; i < 5; i++) send_beat(1'b0, 8'(8'h40 + i), 8'hC0, 8'h90);
      for (int i = 0; i < 8; i++) send_beat(1'b1, 8'h00, 8'h00, 8'h00);

      // Random phases with small frames.
      random_beats = 0;
      while (random_beats < 250) begin
         set_config($urandom_range(0, 7), $urandom_range(1, 12), $urandom_range(1, 8));
         for (int f = $urandom_range(1, 3); f > 0; f--)
            run_frame($urandom % 6 == 0, $urandom % 5 == 0);
      end

      // Extremes, each cut off by the next register write after a short run:
      // the widest frame at the largest radius, the tallest frame with a
      // result on every beat, and a huge frame.
      set_config(7, 2047, 1);
      for (int i = 0; i < 40; i++)
         send_beat($urandom % 10 == 0, channel_value(), channel_value(), channel_value());
      set_config(0, 1, 8191);
      for (int i = 0; i < 40; i++)
         send_beat($urandom % 10 == 0, channel_value(), channel_value(), channel_value());
      set_config(5, 1024, 4096);
      for (int i = 0; i < 40; i++)
         send_beat($urandom % 10 == 0, channel_value(), channel_value(), channel_value());
      set_config(3, 4, 3);
      run_frame(1'b0, 1'b1);

      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("dark_channel_window_min_top_test passed");
      else
         $display("dark_channel_window_min_top_test failed");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #24000000;
      $display("dark_channel_window_min_top_test failed");
      $finish;
   end
endmodule
